/* sv/tbcw_pkg.sv */
// Shared types, constants and helpers for the text box character writer.
// Used by every module of the block but tbcw_ram; depends on nothing.
package tbcw_pkg;

	localparam int MAX_COLUMNS = 40;
	localparam int MAX_ROWS    = 4;
	localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);

	localparam int CODE_W = 8;
	localparam int COL_W  = 6;
	localparam int ROW_W  = 3;
	localparam int CFG_W  = 6;

	localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CODE_W-1:0] END_CODE     = 8'h00;
	localparam logic [COL_W-1:0]  COL_LAST     = '1;

	typedef enum logic [2:0] {
		CMD_TEXT      = 3'd0,
		CMD_GLYPH     = 3'd1,
		CMD_CLEAR_ROW = 3'd2,
		CMD_CLEAR_ALL = 3'd3,
		CMD_READ      = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_SCREEN_COLUMNS = 3'd0,
		CFG_SCREEN_ROWS    = 3'd1,
		CFG_BOX_LEFT       = 3'd2,
		CFG_BOX_TOP        = 3'd3,
		CFG_BOX_WIDTH      = 3'd4,
		CFG_BOX_HEIGHT     = 3'd5,
		CFG_WRAP_ENABLE    = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SCR_NONE,
		SCR_WRITE,
		SCR_CLEAR_ROW,
		SCR_CLEAR_ALL,
		SCR_READ
	} scr_op_t;

	typedef struct packed {
		logic [COL_W-1:0] screen_columns;
		logic [ROW_W-1:0] screen_rows;
		logic [COL_W-1:0] box_left;
		logic [ROW_W-1:0] box_top;
		logic [COL_W-1:0] box_width;
		logic [ROW_W-1:0] box_height;
		logic             wrap_enable;
	} cfg_t;

	// Character write requested by the text cursor unit.
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} txt_wr_t;

	// One access to the screen store.
	typedef struct packed {
		scr_op_t           op;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CODE_W-1:0] code;
	} scr_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row);
		cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

/* sv/tbcw_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module tbcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/tbcw_cursor.sv */
// Text cursor of the character writer: position, end-of-string flag and box clipping.
// Depends on tbcw_pkg.
module tbcw_cursor import tbcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CODE_W-1:0] code,
	input  logic              first,
	input  cfg_t              cfg,
	output txt_wr_t           text_wr,
	output logic [COL_W-1:0]  col,
	output logic [ROW_W-1:0]  row,
	output logic              stopped
);

	logic [COL_W-1:0] col_q, col_e, col_n, col_adv;
	logic [ROW_W-1:0] row_q, row_e, row_n;
	logic             done_q, done_e, done_n, wr_en;
	logic [COL_W:0]   right_sum, max_x;
	logic [ROW_W:0]   bottom_sum, max_y;

	// Box edges clipped to the screen in use.
	always_comb begin
		right_sum  = {1'b0, cfg.box_left} + {1'b0, cfg.box_width};
		bottom_sum = {1'b0, cfg.box_top} + {1'b0, cfg.box_height};
		max_x = ({1'b0, cfg.screen_columns} < right_sum) ? {1'b0, cfg.screen_columns} : right_sum;
		max_y = ({1'b0, cfg.screen_rows} < bottom_sum) ? {1'b0, cfg.screen_rows} : bottom_sum;
	end

	always_comb begin
		col_e   = first ? cfg.box_left : col_q;
		row_e   = first ? cfg.box_top : row_q;
		done_e  = first ? 1'b0 : done_q;
		col_n   = col_e;
		row_n   = row_e;
		done_n  = done_e;
		wr_en   = 1'b0;
		col_adv = (col_e != COL_LAST) ? col_e + COL_W'(1) : col_e;
		if (!done_e) begin
			if (code == END_CODE || {1'b0, row_e} >= max_y) begin
				done_n = 1'b1;
			end else begin
				if (code == NEWLINE_CODE) begin
					col_n = cfg.box_left;
					row_n = row_e + ROW_W'(1);
				end else begin
					wr_en = {1'b0, col_e} < max_x;
					col_n = col_adv;
					if ({1'b0, col_adv} >= max_x) begin
						if (!cfg.wrap_enable) begin
							done_n = 1'b1;
						end else begin
							col_n = cfg.box_left;
							row_n = row_e + ROW_W'(1);
						end
					end
				end
				if ({1'b0, row_n} >= max_y) begin
					done_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b1;
		end else if (step) begin
			col_q  <= col_n;
			row_q  <= row_n;
			done_q <= done_n;
		end
	end

	assign text_wr.en  = step & wr_en;
	assign text_wr.col = col_e;
	assign text_wr.row = row_e;
	assign col         = col_q;
	assign row         = row_q;
	assign stopped     = done_q;

	// An end code always leaves the string stopped.
	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && code == END_CODE |=> done_q)
		else $error("cursor: end code did not stop the string");

	// The cursor only moves on a text item.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(col_q) && $stable(row_q) && $stable(done_q))
		else $error("cursor: state changed without a text item");

	// No character is placed once the string is over.
	a_no_write_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		text_wr.en |-> !done_e && code != END_CODE && code != NEWLINE_CODE)
		else $error("cursor: write issued for a stopped string");

endmodule

/* sv/tbcw_screen.sv */
// Screen cell store: RAM of character codes plus one valid bit per cell that stands
// for the space fill of reset and clears. Depends on tbcw_pkg and tbcw_ram.
module tbcw_screen import tbcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  scr_req_t          req,
	input  logic [COL_W:0]    used_cols,
	input  logic [ROW_W:0]    used_rows,
	output logic              wrote,
	output logic [CODE_W-1:0] rd_char
);

	logic [CELL_COUNT-1:0] valid_q, clr_mask, set_mask;
	logic                  in_range, ram_we, ram_re;
	logic [ADDR_W-1:0]     addr;
	logic [CODE_W-1:0]     ram_rdata;
	logic                  rd_hit_s2, rd_valid_s2;

	assign in_range = ({1'b0, req.col} < used_cols) && ({1'b0, req.row} < used_rows);
	assign addr     = cell_addr(req.col, req.row);
	assign ram_we   = (req.op == SCR_WRITE) && in_range;
	assign ram_re   = (req.op == SCR_READ) && in_range;

	always_comb begin
		unique case (req.op)
			SCR_WRITE:     wrote = in_range;
			SCR_CLEAR_ROW: wrote = ({1'b0, req.row} < (ROW_W + 1)'(MAX_ROWS)) && (used_cols != '0);
			SCR_CLEAR_ALL: wrote = (used_rows != '0) && (used_cols != '0);
			default:       wrote = 1'b0;
		endcase
	end

	// Cells dropped back to space by a row or screen clear.
	always_comb begin
		clr_mask = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				if ((COL_W + 1)'(c) < used_cols &&
						((req.op == SCR_CLEAR_ROW && req.row == ROW_W'(r)) ||
						 (req.op == SCR_CLEAR_ALL && (ROW_W + 1)'(r) < used_rows))) begin
					clr_mask[r * MAX_COLUMNS + c] = 1'b1;
				end
			end
		end
	end

	// The cell taken by a write holds its own code from now on.
	assign set_mask = ram_we ? (CELL_COUNT'(1) << addr) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~clr_mask) | set_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_s2 <= 1'b0;
		end else begin
			rd_hit_s2 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_valid_s2 <= valid_q[addr];
		end
	end

	tbcw_ram #(
		.WIDTH (CODE_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (req.code),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	assign rd_char = rd_hit_s2 ? (rd_valid_s2 ? ram_rdata : SPACE_CODE) : '0;

	// Accesses stay inside the store.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we || ram_re |-> addr < ADDR_W'(CELL_COUNT))
		else $error("screen: cell address beyond the store");

	// A written cell reads back as written, never as the space fill.
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && clr_mask == '0 |=> valid_q[$past(addr)])
		else $error("screen: valid bit not set by a write");

endmodule

/* sv/text_box_char_writer_top.sv */
// Top level of the text box character writer: configuration registers, command
// pipeline and result strobe. Depends on tbcw_pkg, tbcw_cursor and tbcw_screen.

// The block takes one item per clock cycle: busy stays low and every item accepted
// at a rising edge (start high, busy low) produces exactly one result, shown for one
// cycle with done high, after passing through stage 1 (vld_s1) and stage 2 (vld_s2).
// Reads use the registered read of the screen RAM; writes, row clears and screen
// clears all complete in stage 1 because cleared cells are tracked by one valid bit
// per cell, and an invalid cell reads as a space. There is no clearing pass after
// reset. The receiver cannot stall, so results must be taken the cycle they appear.
// The registers are written through cfg_write/cfg_index/cfg_data and must only change
// while no item is in flight.
module text_box_char_writer_top import tbcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [2:0]        command,
	input  logic [CODE_W-1:0] char_code,
	input  logic              first_of_string,
	input  logic [COL_W-1:0]  cell_col,
	input  logic [ROW_W-1:0]  cell_row,
	output logic [CODE_W-1:0] read_char,
	output logic              cell_written,
	output logic              flow_stopped,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	cfg_t              cfg_q;
	logic              vld_s1, vld_s2;
	cmd_t              cmd_s1;
	logic [CODE_W-1:0] code_s1;
	logic              first_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              wrote_s2;
	logic              accept, text_step, scr_wrote;
	logic [COL_W:0]    used_cols;
	logic [ROW_W:0]    used_rows;
	txt_wr_t           text_wr;
	scr_req_t          scr_req;

	// Every item moves through the pipeline without holding the input side.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Configuration registers, reset to a 16 by 2 screen with a full-size box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_columns <= COL_W'(16);
			cfg_q.screen_rows    <= ROW_W'(2);
			cfg_q.box_left       <= '0;
			cfg_q.box_top        <= '0;
			cfg_q.box_width      <= COL_W'(16);
			cfg_q.box_height     <= ROW_W'(2);
			cfg_q.wrap_enable    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_COLUMNS: cfg_q.screen_columns <= cfg_data[COL_W-1:0];
				CFG_SCREEN_ROWS:    cfg_q.screen_rows    <= cfg_data[ROW_W-1:0];
				CFG_BOX_LEFT:       cfg_q.box_left       <= cfg_data[COL_W-1:0];
				CFG_BOX_TOP:        cfg_q.box_top        <= cfg_data[ROW_W-1:0];
				CFG_BOX_WIDTH:      cfg_q.box_width      <= cfg_data[COL_W-1:0];
				CFG_BOX_HEIGHT:     cfg_q.box_height     <= cfg_data[ROW_W-1:0];
				CFG_WRAP_ENABLE:    cfg_q.wrap_enable    <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	// Screen in use, limited to the storage actually built.
	assign used_cols = ({1'b0, cfg_q.screen_columns} < (COL_W + 1)'(MAX_COLUMNS)) ?
		{1'b0, cfg_q.screen_columns} : (COL_W + 1)'(MAX_COLUMNS);
	assign used_rows = ({1'b0, cfg_q.screen_rows} < (ROW_W + 1)'(MAX_ROWS)) ?
		{1'b0, cfg_q.screen_rows} : (ROW_W + 1)'(MAX_ROWS);

	// Stage 1 holds the accepted item while it updates the cursor and the screen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_t'(command);
			code_s1  <= char_code;
			first_s1 <= first_of_string;
			col_s1   <= cell_col;
			row_s1   <= cell_row;
		end
	end

	assign text_step = vld_s1 && (cmd_s1 == CMD_TEXT);

	tbcw_cursor u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (text_step),
		.code    (code_s1),
		.first   (first_s1),
		.cfg     (cfg_q),
		.text_wr (text_wr),
		.col     (cursor_col),
		.row     (cursor_row),
		.stopped (flow_stopped)
	);

	// Turn the command into one access of the screen store. Only one item is ever
	// in stage 1, so a read and a write to the same cell never meet in a cycle.
	always_comb begin
		scr_req.op   = SCR_NONE;
		scr_req.col  = col_s1;
		scr_req.row  = row_s1;
		scr_req.code = code_s1;
		if (vld_s1) begin
			unique case (cmd_s1)
				CMD_TEXT: begin
					scr_req.op  = text_wr.en ? SCR_WRITE : SCR_NONE;
					scr_req.col = text_wr.col;
					scr_req.row = text_wr.row;
				end
				CMD_GLYPH:     scr_req.op = SCR_WRITE;
				CMD_CLEAR_ROW: scr_req.op = SCR_CLEAR_ROW;
				CMD_CLEAR_ALL: scr_req.op = SCR_CLEAR_ALL;
				CMD_READ:      scr_req.op = SCR_READ;
				default:       scr_req.op = SCR_NONE;
			endcase
		end
	end

	tbcw_screen u_screen (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (scr_req),
		.used_cols (used_cols),
		.used_rows (used_rows),
		.wrote     (scr_wrote),
		.rd_char   (read_char)
	);

	// Stage 2 presents the result; the cursor ports already show its new state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			wrote_s2 <= 1'b0;
		end else begin
			vld_s2   <= vld_s1;
			wrote_s2 <= scr_wrote;
		end
	end

	assign done         = vld_s2;
	assign cell_written = wrote_s2;

	// Every accepted item yields its result once it has passed stage 1 and stage 2.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("top: accepted item gave no result");

	// No result appears without an item behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1))
		else $error("top: result without an item");

	// Read data is only nonzero for a read item.
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_char != '0 |-> $past(cmd_s1) == CMD_READ && !cell_written)
		else $error("top: read data on a non-read item");

endmodule
